>>> hdl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// No dependencies; used by every module of the block.
package tcw_pkg;

	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	localparam logic [7:0] NEWLINE_CHAR = 8'd10;
	localparam logic [7:0] BLANK_CHAR   = 8'd32;

	// register indexes on the configuration port
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 1'b1;
	localparam int CFG_DATA_W = 4;

	typedef enum logic [1:0] {
		KIND_PUT   = 2'd0,
		KIND_CLEAR = 2'd1,
		KIND_READ  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  character;
		logic [10:0] cell_index;
	} cmd_t;

	typedef struct packed {
		logic [6:0] cursor_column;
		logic [4:0] cursor_row;
		logic [7:0] cell_character;
		logic [7:0] cell_attribute;
	} rsp_t;

endpackage

>>> hdl/tcw_screen_ram.sv
// Screen memory: one write port, one read port, registered read data.
// Depends on tcw_pkg for its default depth; instantiated by text_console_writer.
module tcw_screen_ram #(
	parameter int DEPTH = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
	parameter int DW    = 16,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/tcw_sequencer.sv
// Command sequencer: cursor state, put/newline/scroll/clear/read walks over
// the screen memory. Depends on tcw_pkg; drives tcw_screen_ram.
module tcw_sequencer #(
	parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS    = tcw_pkg::DEF_ROWS,
	localparam int CELLS  = COLUMNS * ROWS,
	localparam int AW     = $clog2(CELLS),
	localparam int CW     = $clog2(COLUMNS + 1),
	localparam int RW     = $clog2(ROWS)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  tcw_pkg::cmd_t  cmd,
	input  logic [7:0]     attr,
	output logic           res_valid,
	input  logic           res_take,
	output tcw_pkg::rsp_t  res,
	output logic           ram_we,
	output logic [AW-1:0]  ram_waddr,
	output logic [15:0]    ram_wdata,
	output logic [AW-1:0]  ram_raddr,
	input  logic [15:0]    ram_rdata
);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_DISPATCH = 7'b0000010,
		ST_WRITE    = 7'b0000100,
		ST_SCROLL   = 7'b0001000,
		ST_FILL     = 7'b0010000,
		ST_READ     = 7'b0100000,
		ST_DONE     = 7'b1000000
	} state_t;

	state_t          state_q;
	tcw_pkg::kind_t  kind_q;
	logic [7:0]      char_q;
	logic [10:0]     idx_q;
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic [AW-1:0]   ptr_q;
	logic [AW-1:0]   end_q;
	logic            copy_end_q;
	logic            pend_q;      // a character write follows the scroll
	logic            cp_valid_s1;
	logic [AW-1:0]   cp_addr_s1;
	logic [7:0]      rd_char_q;
	logic [7:0]      rd_attr_q;

	logic [AW-1:0]   cur_addr;
	logic            at_bottom;
	logic            idx_ok;
	logic            issue_copy;

	assign cur_addr   = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
	assign at_bottom  = !(row_q < RW'(ROWS - 1));
	assign idx_ok     = 32'(idx_q) < 32'(CELLS);
	assign issue_copy = (state_q == ST_SCROLL) && !copy_end_q;

	assign cmd_stall = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_DONE);

	always_comb begin
		res.cursor_column  = 7'(col_q);
		res.cursor_row     = 5'(row_q);
		res.cell_character = rd_char_q;
		res.cell_attribute = rd_attr_q;
	end

	// read port: scroll source walk, otherwise the requested cell
	assign ram_raddr = (state_q == ST_SCROLL) ? ptr_q : AW'(idx_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_addr;
		ram_wdata = {attr, char_q};
		case (state_q)
			ST_SCROLL: begin
				ram_we    = cp_valid_s1;
				ram_waddr = cp_addr_s1;
				ram_wdata = ram_rdata;
			end
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q;
				ram_wdata = {attr, tcw_pkg::BLANK_CHAR};
			end
			ST_WRITE: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// copy pipeline: read issued in one cycle, written back the next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_valid_s1 <= 1'b0;
		end else begin
			cp_valid_s1 <= issue_copy;
		end
	end

	always_ff @(posedge clk) begin
		cp_addr_s1 <= ptr_q - AW'(COLUMNS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			col_q      <= '0;
			row_q      <= '0;
			kind_q     <= tcw_pkg::KIND_NONE;
			char_q     <= '0;
			idx_q      <= '0;
			ptr_q      <= '0;
			end_q      <= '0;
			copy_end_q <= 1'b0;
			pend_q     <= 1'b0;
			rd_char_q  <= '0;
			rd_attr_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						kind_q    <= cmd.kind;
						char_q    <= cmd.character;
						idx_q     <= cmd.cell_index;
						rd_char_q <= '0;
						rd_attr_q <= '0;
						state_q   <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					copy_end_q <= 1'b0;
					ptr_q      <= AW'(COLUMNS);
					case (kind_q)
						tcw_pkg::KIND_PUT: begin
							if (char_q == tcw_pkg::NEWLINE_CHAR ||
							    !(col_q < CW'(COLUMNS))) begin
								// newline, explicit or from a full row
								pend_q <= (char_q != tcw_pkg::NEWLINE_CHAR);
								col_q  <= '0;
								if (at_bottom) begin
									state_q <= ST_SCROLL;
								end else begin
									row_q   <= row_q + RW'(1);
									state_q <= (char_q != tcw_pkg::NEWLINE_CHAR) ?
									           ST_WRITE : ST_DONE;
								end
							end else begin
								state_q <= ST_WRITE;
							end
						end
						tcw_pkg::KIND_CLEAR: begin
							pend_q  <= 1'b0;
							col_q   <= '0;
							row_q   <= '0;
							ptr_q   <= '0;
							end_q   <= AW'(CELLS - 1);
							state_q <= ST_FILL;
						end
						tcw_pkg::KIND_READ: begin
							state_q <= idx_ok ? ST_READ : ST_DONE;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_WRITE: begin
					col_q   <= col_q + CW'(1);
					state_q <= ST_DONE;
				end
				ST_SCROLL: begin
					if (!copy_end_q) begin
						if (ptr_q == AW'(CELLS - 1)) begin
							copy_end_q <= 1'b1;
						end else begin
							ptr_q <= ptr_q + AW'(1);
						end
					end else if (!cp_valid_s1) begin
						ptr_q   <= AW'(CELLS - COLUMNS);
						end_q   <= AW'(CELLS - 1);
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					if (ptr_q == end_q) begin
						state_q <= pend_q ? ST_WRITE : ST_DONE;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				ST_READ: begin
					rd_char_q <= ram_rdata[7:0];
					rd_attr_q <= ram_rdata[15:8];
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hdl/text_console_writer.sv
// Text console writer top level: colour registers, result register,
// sequencer and screen memory. Depends on tcw_pkg, tcw_sequencer, tcw_screen_ram.
//
//  channel | words               | handshake            | direction
//  --------+---------------------+----------------------+----------
//  cmd     | tcw_pkg::cmd_t      | cmd_valid/cmd_stall  | in
//  rsp     | tcw_pkg::rsp_t      | rsp_valid/rsp_stall  | out
//  cfg     | cfg_index, cfg_data | cfg_we, no wait      | in
//
// One command word at a time; cmd_stall stays high until its result word
// has moved into the output register. A command goes from IDLE through
// DISPATCH to WRITE, SCROLL, FILL or READ as it needs, and a read past the
// screen skips READ; then it waits in DONE. Scroll and clear are both bound
// by the single write port of the screen memory (one cell per cycle).
// Reset clears cursor, colours (white on black) and control; the screen
// memory is not cleared, so a cell must be written before it is read.
// A stalled result word waits in the output register while the next
// command word is taken.
module text_console_writer #(
	parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cmd_valid,
	output logic                             cmd_stall,
	input  tcw_pkg::cmd_t                    cmd,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output tcw_pkg::rsp_t                    rsp,
	input  logic                             cfg_we,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);

	logic [3:0]     fg_q;
	logic [3:0]     bg_q;
	logic           rsp_valid_q;
	tcw_pkg::rsp_t  rsp_q;

	logic           res_valid;
	logic           res_take;
	tcw_pkg::rsp_t  res;

	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [15:0]    ram_wdata;
	logic [AW-1:0]  ram_raddr;
	logic [15:0]    ram_rdata;

	// colour registers; attribute is bg in the high nibble, fg in the low
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= 4'd15;
			bg_q <= 4'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				tcw_pkg::REG_FOREGROUND: fg_q <= cfg_data;
				tcw_pkg::REG_BACKGROUND: bg_q <= cfg_data;
				default: begin
					fg_q <= fg_q;
				end
			endcase
		end
	end

	// output register: loads when empty or being drained this cycle
	assign res_take = res_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	tcw_sequencer #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.attr      ({bg_q, fg_q}),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	tcw_screen_ram #(
		.DEPTH (CELLS),
		.DW    (16)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
